// ===== sv/pl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pl_pkg
// Shared types and constants for the positional list engine.
// ---------------------------------------------------------------------------
package pl_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 16;
    localparam int COUNT_W          = 5;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic                     element_valid;
        logic                     last;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request beat
        logic exec;       // perform edit, emit single result
        logic dump_step;  // emit front cell, rotate list
    } pl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a beat this cycle
        logic dump_go;    // held op is a dump of a non-empty list
        logic dump_final; // next dump beat is the last one
    } pl_stat_t;

endpackage
`default_nettype wire

// ===== sv/pl_stream_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pl_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ---------------------------------------------------------------------------
interface pl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pl_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pl_ctrl
// Sequencer: takes one request, then runs the edit or the dump stream.
// ---------------------------------------------------------------------------
module pl_ctrl
    import pl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire pl_stat_t stat,
    output pl_cmd_t       cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        req_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    if (stat.dump_go)
                    begin
                        cmd.dump_step = 1'b1;
                        if (stat.dump_final)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.exec   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/pl_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pl_datapath
// Shifting cell row, occupancy, held request, dump counter, output register.
// ---------------------------------------------------------------------------
module pl_datapath
    import pl_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req_data,
    input  wire pl_cmd_t  cmd,
    output pl_stat_t      stat,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output rsp_t          rsp_data
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] cells_reg  [CAPACITY];
    logic signed [DATA_W-1:0] cells_next [CAPACITY];
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;
    logic [OCC_W-1:0]         rem_reg;
    req_t                     hold_reg;
    logic                     out_valid_reg;
    rsp_t                     out_reg;

    logic [POS_W:0]   pos_ext;
    logic [POS_W:0]   occ_ext;
    logic [OCC_W-1:0] pos_idx;
    logic [OCC_W-1:0] k_idx;
    logic             is_ins;
    logic             is_del;
    logic             do_ins;
    logic             do_del;
    logic             empty;
    status_t          st;

    assign empty   = (occ_reg == '0);
    assign pos_ext = {1'b0, hold_reg.position};
    assign occ_ext = (POS_W+1)'(occ_reg);
    assign pos_idx = OCC_W'(hold_reg.position - POS_W'(1));

    assign is_ins = (hold_reg.op == OP_INS_FRONT) || (hold_reg.op == OP_INS_BACK)
                 || (hold_reg.op == OP_INS_POS);
    assign is_del = (hold_reg.op == OP_DEL_FRONT) || (hold_reg.op == OP_DEL_BACK)
                 || (hold_reg.op == OP_DEL_POS);

    // Status and edit slot; full/empty take priority over the position check.
    always_comb
    begin
        st    = ST_OK;
        k_idx = '0;
        case (hold_reg.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS:
            begin
                if (occ_reg == OCC_W'(CAPACITY))
                begin
                    st = ST_FULL;
                end
                else if (hold_reg.op == OP_INS_FRONT)
                begin
                    k_idx = '0;
                end
                else if (hold_reg.op == OP_INS_BACK)
                begin
                    k_idx = occ_reg;
                end
                else if (pos_ext == '0 || pos_ext > occ_ext + (POS_W+1)'(1))
                begin
                    st = ST_BADPOS;
                end
                else
                begin
                    k_idx = pos_idx;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (hold_reg.op == OP_DEL_FRONT)
                begin
                    k_idx = '0;
                end
                else if (hold_reg.op == OP_DEL_BACK)
                begin
                    k_idx = occ_reg - OCC_W'(1);
                end
                else if (pos_ext == '0 || pos_ext > occ_ext)
                begin
                    st = ST_BADPOS;
                end
                else
                begin
                    k_idx = pos_idx;
                end
            end
            OP_DUMP:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign do_ins = cmd.exec && is_ins && (st == ST_OK);
    assign do_del = cmd.exec && is_del && (st == ST_OK);

    // Each cell looks only at itself, its neighbors and the front cell.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins)
            begin
                if (OCC_W'(i) == k_idx)
                begin
                    cells_next[i] = hold_reg.value;
                end
                else if (i > 0 && OCC_W'(i) > k_idx)
                begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_del)
            begin
                if (i < CAPACITY - 1 && OCC_W'(i) >= k_idx)
                begin
                    cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
            else if (cmd.dump_step)
            begin
                // rotate the occupied cells by one toward the front
                if (OCC_W'(i) == occ_reg - OCC_W'(1))
                begin
                    cells_next[i] = cells_reg[0];
                end
                else if (i < CAPACITY - 1 && OCC_W'(i) < occ_reg - OCC_W'(1))
                begin
                    cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (do_ins)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (do_del)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
        if (cmd.load)
        begin
            hold_reg <= req_data;
        end
        if (cmd.exec)
        begin
            out_reg.status        <= st;
            out_reg.element       <= '0;
            out_reg.element_valid <= 1'b0;
            out_reg.last          <= 1'b1;
            out_reg.count         <= COUNT_W'(occ_next);
        end
        else if (cmd.dump_step)
        begin
            out_reg.status        <= ST_OK;
            out_reg.element       <= cells_reg[0];
            out_reg.element_valid <= 1'b1;
            out_reg.last          <= (rem_reg == OCC_W'(1));
            out_reg.count         <= COUNT_W'(occ_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cmd.load)
            begin
                rem_reg <= occ_reg;
            end
            else if (cmd.dump_step)
            begin
                rem_reg <= rem_reg - OCC_W'(1);
            end
            if (cmd.exec || cmd.dump_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free   = !out_valid_reg || rsp_ready;
    assign stat.dump_go    = (hold_reg.op == OP_DUMP) && !empty;
    assign stat.dump_final = (rem_reg == OCC_W'(1));

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule
`default_nettype wire

// ===== sv/positional_list_engine.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with positional edits and dump.
// ---------------------------------------------------------------------------
// One request at a time. An edit (insert or delete at front, back or a
// 1-based position) first has its request beat captured; then the whole
// cell row shifts in parallel and the single result beat is loaded into
// the output register. A dump of N elements gives N beats: with each beat
// the front cell goes out and the occupied cells rotate by one, so after
// the last beat the list is back in order. A stalled output holds up these
// steps; a new request is taken while the last result of the previous one
// still sits in the output register. Illegal edits leave the list untouched
// and report bad position, full or empty in status.
// ---------------------------------------------------------------------------
module positional_list_engine
    import pl_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    pl_stream_if.sink    req,
    pl_stream_if.source  rsp
);

    pl_cmd_t  cmd;
    pl_stat_t stat;

    pl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data)
    );

endmodule
`default_nettype wire

// ===== sv/pl_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pl_checker
// Port-level checks for the positional list engine, bound to the top level.
// ---------------------------------------------------------------------------
module pl_checker
    import pl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_data
);

    // a held result beat may not change under backpressure
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("result beat changed while stalled");

    // one request in flight: no back-to-back request beats
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous one in work");

    // listed elements only appear in successful dump beats
    a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.element_valid) |-> (rsp_data.status == ST_OK))
        else $error("element beat with bad status");

    // non-dump beats are single, terminal and carry a zero element
    a_edit_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.element_valid)
            |-> (rsp_data.last && rsp_data.element == '0))
        else $error("edit result beat malformed");

endmodule

bind positional_list_engine pl_checker u_pl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
`default_nettype wire
